FILE: design/bblt_pkg.sv
// shared types and constants of the banked bounded list table
package bblt_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 4;
    localparam int COUNT_W  = 5;

    // command codes
    localparam logic [2:0] CMD_CREATE      = 3'd0;
    localparam logic [2:0] CMD_APPEND      = 3'd1;
    localparam logic [2:0] CMD_RM_VALUE    = 3'd2;
    localparam logic [2:0] CMD_RM_LAST     = 3'd3;
    localparam logic [2:0] CMD_RESIZE      = 3'd4;
    localparam logic [2:0] CMD_READ        = 3'd5;
    localparam logic [2:0] CMD_READ_SORTED = 3'd6;
    localparam logic [2:0] CMD_NOP         = 3'd7;

    // status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_BAD_REGION   = 4'd1;
    localparam logic [3:0] ST_BAD_SIZE     = 4'd2;
    localparam logic [3:0] ST_EXISTS       = 4'd3;
    localparam logic [3:0] ST_NO_MEMORY    = 4'd4;
    localparam logic [3:0] ST_NONE         = 4'd5;
    localparam logic [3:0] ST_FULL         = 4'd6;
    localparam logic [3:0] ST_EMPTY        = 4'd7;
    localparam logic [3:0] ST_BAD_NEW_SIZE = 4'd8;

    // how a decoded command is carried out
    typedef enum logic [1:0] {
        KIND_SINGLE,
        KIND_REMOVE,
        KIND_READ
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic emit_single;
        logic emit_remove;
        logic emit_elem;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  scan_done;
        logic  out_free;
        logic  last_elem;
    } dp_stat_t;

endpackage

FILE: design/bblt_ram.sv
// generic single write port, single registered read port ram
module bblt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 160
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/bblt_ctrl.sv
// sequencing state machine of the banked bounded list table
module bblt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output bblt_pkg::dp_cmd_t  cmd,
    input  bblt_pkg::dp_stat_t stat
);

    import bblt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RM_SCAN,
        S_RM_FIN,
        S_RD_SCAN,
        S_RD_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                unique case (stat.kind)
                    KIND_REMOVE:
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_RM_SCAN;
                    end
                    KIND_READ:
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_RD_SCAN;
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit_single = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end
                endcase
            end
            S_RM_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_RM_FIN;
                end
            end
            S_RM_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_remove = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_RD_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_RD_EMIT;
                end
            end
            S_RD_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_elem = 1'b1;
                    state_next    = stat.last_elem ? S_IDLE : S_RD_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    // state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

FILE: design/bblt_dp.sv
// region tables, element store, scan unit and result register
module bblt_dp #(
    parameter int REGIONS      = 10,
    parameter int MAX_CAPACITY = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bblt_pkg::dp_cmd_t                     cmd,
    output bblt_pkg::dp_stat_t                    stat,
    input  logic [2:0]                            command,
    input  logic [3:0]                            region,
    input  logic signed [bblt_pkg::DATA_W-1:0]    value,
    input  logic signed [6:0]                     size_amount,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bblt_pkg::STATUS_W-1:0]         status,
    output logic signed [bblt_pkg::DATA_W-1:0]    data_value,
    output logic [bblt_pkg::COUNT_W-1:0]          element_count,
    output logic                                  last_result
);

    import bblt_pkg::*;

    localparam int RIW   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int CW    = $clog2(MAX_CAPACITY + 1);
    localparam int OW    = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int DEPTH = REGIONS * MAX_CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = ((CW > 7) ? CW : 7) + 2;
    localparam logic signed [SW-1:0] MAX_S   = SW'(MAX_CAPACITY);
    localparam logic [CW-1:0]        MAX_C   = CW'(MAX_CAPACITY);
    localparam logic [4:0]           REG_LIM = 5'(REGIONS);

    // latched command
    logic [2:0]               cmd_reg;
    logic                     reg_ok_reg;
    logic [RIW-1:0]           ridx_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [6:0]        amt_reg;
    logic [3:0]               region_m1;

    // region tables
    logic          exists_reg [REGIONS];
    logic [CW-1:0] cap_reg    [REGIONS];
    logic [CW-1:0] cnt_reg    [REGIONS];

    // scan unit
    logic [CW-1:0]            k_reg;
    logic [CW-1:0]            issue_reg;
    logic                     pend_reg;
    logic [CW-1:0]            pend_idx_reg;
    logic                     found_reg;
    logic                     have_best_reg;
    logic signed [DATA_W-1:0] best_val_reg;
    logic [CW-1:0]            best_idx_reg;
    logic signed [DATA_W-1:0] last_val_reg;
    logic [CW-1:0]            last_idx_reg;

    // result register
    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic                     last_reg;

    // combinational
    logic                     cur_ex;
    logic [CW-1:0]            cur_cap;
    logic [CW-1:0]            cur_cnt;
    logic signed [SW-1:0]     amt_s;
    logic signed [SW-1:0]     nc_s;
    logic [CW-1:0]            nc_u;
    kind_t                    kind;
    logic [STATUS_W-1:0]      sst;
    logic [CW-1:0]            new_cnt;
    logic                     do_create;
    logic                     do_append;
    logic                     do_resize;
    logic                     do_dec;
    logic                     is_rm;
    logic                     is_sorted;
    logic [CW-1:0]            scan_end;
    logic                     issuing;
    logic [AW-1:0]            base;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     wr_en;
    logic [DATA_W-1:0]        rdata_u;
    logic signed [DATA_W-1:0] rdata;
    logic [CW-1:0]            pend_m1;
    logic                     above_last;
    logic                     below_best;
    logic                     take_cand;
    logic [CW-1:0]            rm_cnt;
    logic [CW-1:0]            emit_cnt;
    logic [CW+4:0]            emit_cnt_ext;

    assign region_m1 = region - 4'd1;

    // current region view
    assign cur_ex  = reg_ok_reg && exists_reg[ridx_reg];
    assign cur_cap = reg_ok_reg ? cap_reg[ridx_reg] : '0;
    assign cur_cnt = reg_ok_reg ? cnt_reg[ridx_reg] : '0;
    assign amt_s   = SW'(amt_reg);
    assign nc_s    = signed'(SW'(cur_cap)) + amt_s;
    assign nc_u    = nc_s[CW-1:0];

    // command decode and checks in the documented order
    always_comb
    begin
        kind      = KIND_SINGLE;
        sst       = ST_OK;
        new_cnt   = cur_cnt;
        do_create = 1'b0;
        do_append = 1'b0;
        do_resize = 1'b0;
        do_dec    = 1'b0;
        if (!reg_ok_reg)
        begin
            sst = (cmd_reg == CMD_NOP) ? ST_OK : ST_BAD_REGION;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_CREATE:
                begin
                    if (amt_s <= 0)
                        sst = ST_BAD_SIZE;
                    else if (cur_ex)
                        sst = ST_EXISTS;
                    else if (amt_s > MAX_S)
                        sst = ST_NO_MEMORY;
                    else
                    begin
                        do_create = 1'b1;
                        new_cnt   = '0;
                    end
                end
                CMD_APPEND:
                begin
                    if (!cur_ex)
                        sst = ST_NONE;
                    else if (cur_cnt >= cur_cap || cur_cnt >= MAX_C)
                        sst = ST_FULL;
                    else
                    begin
                        do_append = 1'b1;
                        new_cnt   = cur_cnt + 1'b1;
                    end
                end
                CMD_RM_VALUE:
                begin
                    if (!cur_ex)
                        sst = ST_NONE;
                    else
                        kind = KIND_REMOVE;
                end
                CMD_RM_LAST:
                begin
                    if (!cur_ex)
                        sst = ST_NONE;
                    else if (cur_cnt == '0)
                        sst = ST_EMPTY;
                    else
                    begin
                        do_dec  = 1'b1;
                        new_cnt = cur_cnt - 1'b1;
                    end
                end
                CMD_RESIZE:
                begin
                    if (nc_s <= 0)
                        sst = ST_BAD_NEW_SIZE;
                    else if (!cur_ex)
                        sst = ST_NONE;
                    else if (nc_s > MAX_S)
                        sst = ST_NO_MEMORY;
                    else
                    begin
                        do_resize = 1'b1;
                        new_cnt   = (cur_cnt > nc_u) ? nc_u : cur_cnt;
                    end
                end
                CMD_READ, CMD_READ_SORTED:
                begin
                    if (!cur_ex)
                        sst = ST_NONE;
                    else if (cur_cnt != '0)
                        kind = KIND_READ;
                end
                default:
                begin
                    sst = ST_OK;
                end
            endcase
        end
    end

    // scan addressing
    assign is_rm     = (cmd_reg == CMD_RM_VALUE);
    assign is_sorted = (cmd_reg == CMD_READ_SORTED);
    assign scan_end  = (cmd_reg == CMD_READ) ? k_reg + 1'b1 : cur_cnt;
    assign issuing   = cmd.step && (issue_reg < scan_end);
    assign base      = AW'(ridx_reg) * AW'(MAX_CAPACITY);
    assign rd_addr   = base + AW'(issue_reg[OW-1:0]);
    assign pend_m1   = pend_idx_reg - 1'b1;
    assign rdata     = signed'(rdata_u);

    // store port: append, or left shift behind the removed word
    always_comb
    begin
        if (cmd.emit_single && do_append)
        begin
            wr_en   = 1'b1;
            wr_addr = base + AW'(cur_cnt[OW-1:0]);
            wr_data = value_reg;
        end
        else
        begin
            wr_en   = pend_reg && is_rm && found_reg;
            wr_addr = base + AW'(pend_m1[OW-1:0]);
            wr_data = rdata_u;
        end
    end

    // next candidate for a read: smallest (word, place) above the last one given
    assign above_last = !is_sorted || (k_reg == '0) ||
                        (last_val_reg < rdata) ||
                        (last_val_reg == rdata && last_idx_reg < pend_idx_reg);
    assign below_best = !have_best_reg || (rdata < best_val_reg) ||
                        (rdata == best_val_reg && pend_idx_reg < best_idx_reg);
    assign take_cand  = pend_reg && !is_rm && above_last && below_best;

    assign rm_cnt = cur_cnt - CW'(found_reg);

    // status back to the controller
    assign stat.kind      = kind;
    assign stat.scan_done = !(issue_reg < scan_end) && !pend_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.last_elem = (k_reg + 1'b1 == cur_cnt);

    bblt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata_u)
    );

    // latched command fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg    <= command;
            reg_ok_reg <= (region != 4'd0) && ({1'b0, region} <= REG_LIM);
            ridx_reg   <= region_m1[RIW-1:0];
            value_reg  <= value;
            amt_reg    <= size_amount;
        end
    end

    // region tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REGIONS; i++)
            begin
                exists_reg[i] <= 1'b0;
                cap_reg[i]    <= '0;
                cnt_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cmd.emit_single && do_create)
            begin
                exists_reg[ridx_reg] <= 1'b1;
                cap_reg[ridx_reg]    <= amt_s[CW-1:0];
                cnt_reg[ridx_reg]    <= '0;
            end
            if (cmd.emit_single && (do_append || do_dec))
            begin
                cnt_reg[ridx_reg] <= new_cnt;
            end
            if (cmd.emit_single && do_resize)
            begin
                cap_reg[ridx_reg] <= nc_u;
                cnt_reg[ridx_reg] <= new_cnt;
            end
            if (cmd.emit_remove && found_reg)
            begin
                cnt_reg[ridx_reg] <= rm_cnt;
            end
        end
    end

    // scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            have_best_reg <= 1'b0;
            k_reg         <= '0;
            issue_reg     <= '0;
        end
        else if (cmd.start)
        begin
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            have_best_reg <= 1'b0;
            k_reg         <= '0;
            issue_reg     <= '0;
        end
        else if (cmd.emit_elem)
        begin
            have_best_reg <= 1'b0;
            k_reg         <= k_reg + 1'b1;
            issue_reg     <= is_sorted ? '0 : k_reg + 1'b1;
        end
        else if (cmd.step)
        begin
            pend_reg <= issuing;
            if (issuing)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (pend_reg && is_rm && !found_reg && rdata == value_reg)
            begin
                found_reg <= 1'b1;
            end
            if (take_cand)
            begin
                have_best_reg <= 1'b1;
            end
        end
    end

    // scan payload
    always_ff @(posedge clk)
    begin
        if (cmd.step && issuing)
        begin
            pend_idx_reg <= issue_reg;
        end
        if (cmd.step && take_cand)
        begin
            best_val_reg <= rdata;
            best_idx_reg <= pend_idx_reg;
        end
        if (cmd.emit_elem)
        begin
            last_val_reg <= best_val_reg;
            last_idx_reg <= best_idx_reg;
        end
    end

    // result count selection
    always_comb
    begin
        if (cmd.emit_remove)
            emit_cnt = rm_cnt;
        else if (cmd.emit_elem)
            emit_cnt = cur_cnt;
        else
            emit_cnt = new_cnt;
    end
    assign emit_cnt_ext = (CW + 5)'(emit_cnt);

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_single || cmd.emit_remove || cmd.emit_elem)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_single || cmd.emit_remove || cmd.emit_elem)
        begin
            status_reg <= cmd.emit_single ? sst : ST_OK;
            data_reg   <= cmd.emit_elem ? best_val_reg : '0;
            count_reg  <= emit_cnt_ext[COUNT_W-1:0];
            last_reg   <= cmd.emit_elem ? stat.last_elem : 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign data_value    = data_reg;
    assign element_count = count_reg;
    assign last_result   = last_reg;

endmodule

FILE: design/banked_bounded_list_table.sv
// Banked bounded list table: REGIONS numbered regions (1 to REGIONS), each holding up to
// MAX_CAPACITY signed words in one shared element RAM with a single read port. One item
// is handled at a time. Create, append, remove last, resize, the unused command and every
// error give their result straight from the check state. Remove value scans the region
// once through the RAM read port, compacting as it goes. A sorted read rescans the region
// for each element. A new item is taken once the last result of the previous one sits in
// the output register.
module banked_bounded_list_table #(
    parameter int REGIONS      = 10,
    parameter int MAX_CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         command,
    input  logic [3:0]                         region,
    input  logic signed [bblt_pkg::DATA_W-1:0] value,
    input  logic signed [6:0]                  size_amount,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bblt_pkg::STATUS_W-1:0]      status,
    output logic signed [bblt_pkg::DATA_W-1:0] data_value,
    output logic [bblt_pkg::COUNT_W-1:0]       element_count,
    output logic                               last_result
);

    import bblt_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    bblt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

    bblt_dp #(
        .REGIONS      (REGIONS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .command       (command),
        .region        (region),
        .value         (value),
        .size_amount   (size_amount),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_value    (data_value),
        .element_count (element_count),
        .last_result   (last_result)
    );

    // one item in flight: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while another is in flight");

    // only a read element that is not the final one leaves last low, always with ok
    a_non_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_result) |-> (status == ST_OK))
        else $error("non-final result with error status");

    // no new item may start while a non-final result still waits
    a_no_accept_mid_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_result) |-> !in_ready)
        else $error("input ready in the middle of a read");

endmodule
